// ===== hw/rtl/lru_slot_cache_with_prefetch_defines.svh =====
// Assertion helpers shared by the RTL files
`ifndef LRU_SLOT_CACHE_WITH_PREFETCH_DEFINES_SVH
`define LRU_SLOT_CACHE_WITH_PREFETCH_DEFINES_SVH

// clocked implication check, quiet during reset
`define LSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// check that must hold on every edge outside reset
`define LSC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== hw/rtl/lsc_pkg.sv =====
`timescale 1ns / 1ps
package lsc_pkg;
  localparam int MaxSlots   = 8;
  localparam int SlotW      = 3;
  localparam int TagW       = 8;
  localparam int StampW     = 32;
  localparam int AddrW      = 29;

  localparam logic [1:0] OP_REQUEST  = 2'd0;
  localparam logic [1:0] OP_ACQUIRE  = 2'd1;
  localparam logic [1:0] OP_PREFETCH = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  localparam logic [2:0] OUT_NONE  = 3'd0;
  localparam logic [2:0] OUT_HIT   = 3'd1;
  localparam logic [2:0] OUT_PHIT  = 3'd2;
  localparam logic [2:0] OUT_MISS  = 3'd3;
  localparam logic [2:0] OUT_UNAV  = 3'd4;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_EXPERTS = 2'd2;
  localparam logic [1:0] REG_SLOTS  = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load_op;      // latch the input item
    logic settle;       // retire the transfer in flight
    logic clr_wish;
    logic set_wish;
    logic scan_start;   // clear the search and victim registers
    logic scan_step;    // examine slot at scan pointer
    logic scan_wish;    // scan with the wish's expert and protect
    logic load_victim;  // start a load into the chosen victim
    logic load_spec;
    logic touch_hit;
    logic acquire_fix;  // acquire on a hit: clear the slot's spec flag
    logic mul_start;
    logic emit_cmd;
    logic emit_ans;
  } lsc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       id_ok;
    logic       self_prot;
    logic       busy_in;
    logic       flight_valid;
    logic       wish_valid;
    logic       wish_ok;
    logic       scan_done;
    logic       found;
    logic       found_busy;
    logic       victim_ok;
    logic       mul_done;
    logic       out_full;
  } lsc_stat_t;
endpackage

// ===== hw/rtl/lsc_datapath.sv =====
`timescale 1ns / 1ps
`include "lru_slot_cache_with_prefetch_defines.svh"
module lsc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_expert,
  input  logic [7:0]          in_protect,
  input  logic                in_protect_valid,
  input  logic                in_busy,
  input  lsc_pkg::lsc_cmd_t   cmd,
  output lsc_pkg::lsc_stat_t  stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [39:0]         out_data,
  output logic                out_kind,
  output logic                out_last
);
  import lsc_pkg::*;

  logic [31:0] source_base;
  logic [24:0] block_length;
  logic [8:0]  expert_count;
  logic [3:0]  slot_count;

  logic [TagW-1:0]   slot_tag   [MaxSlots];
  logic [MaxSlots-1:0] slot_full, slot_busy, slot_spec;
  logic [StampW-1:0] slot_stamp [MaxSlots];
  logic [StampW-1:0] use_clock;
  logic              flight_valid;
  logic [SlotW-1:0]  flight_slot;
  logic              wish_valid;
  logic [7:0]        wish_expert;
  logic [8:0]        wish_protect;

  logic [1:0]  op;
  logic [7:0]  expert;
  logic [7:0]  prot_id;
  logic        prot_val;
  logic        busy;

  // search state
  logic [3:0]        ptr;
  logic              found;
  logic [SlotW-1:0]  found_slot;
  logic              vic_ok;
  logic              vic_free;
  logic [SlotW-1:0]  vic_slot;
  logic [StampW-1:0] oldest;

  // serial address multiply, one bit of expert a cycle, kept modulo 2^32
  logic [31:0] acc;
  logic [7:0]  mul_e;
  logic [3:0]  mul_cnt;

  logic [3:0]  used;
  logic [7:0]  s_exp;
  logic [8:0]  s_prot;
  logic [SlotW-1:0] p;
  logic [SlotW-1:0] ans_slot;
  logic        ans_ready;
  logic [2:0]  ans_out;
  logic [2:0]  acq_out;

  assign used  = (slot_count > 4'(MaxSlots)) ? 4'(MaxSlots) : slot_count;
  assign s_exp  = cmd.scan_wish ? wish_expert : expert;
  assign s_prot = cmd.scan_wish ? wish_protect
                : ((op == OP_PREFETCH && prot_val) ? {1'b1, prot_id} : 9'd0);
  assign p = ptr[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= '0;
      block_length <= 25'd8;
      expert_count <= 9'd1;
      slot_count <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:    source_base <= cfg_data;
        REG_LENGTH:  block_length <= cfg_data[24:0];
        REG_EXPERTS: expert_count <= cfg_data[8:0];
        REG_SLOTS:   slot_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op <= in_op;
      expert <= in_expert;
      prot_id <= in_protect;
      prot_val <= in_protect_valid;
      busy <= in_busy;
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr <= '0;
      found <= 1'b0;
      found_slot <= '0;
      vic_ok <= 1'b0;
      vic_free <= 1'b0;
      vic_slot <= '0;
      oldest <= '1;
    end else if (cmd.scan_step && ptr < used) begin
      ptr <= ptr + 4'd1;
      if (!found && slot_full[p] && slot_tag[p] == s_exp) begin
        found <= 1'b1;
        found_slot <= p;
      end
      if (!vic_free && !slot_busy[p]) begin
        if (!slot_full[p]) begin
          vic_free <= 1'b1;
          vic_ok <= 1'b1;
          vic_slot <= p;
        end else if (!(s_prot[8] && slot_tag[p] == s_prot[7:0])
                     && slot_stamp[p] < oldest) begin
          oldest <= slot_stamp[p];
          vic_ok <= 1'b1;
          vic_slot <= p;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      acc <= source_base;
      mul_e <= s_exp;
      mul_cnt <= '0;
    end else if (mul_cnt < 4'd8) begin
      mul_cnt <= mul_cnt + 4'd1;
      if (mul_e[mul_cnt[2:0]])
        acc <= acc + ({7'd0, block_length} << mul_cnt[2:0]);
    end
  end

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= '0;
      slot_busy <= '0;
      slot_spec <= '0;
      use_clock <= '0;
      flight_valid <= 1'b0;
      flight_slot <= '0;
      wish_valid <= 1'b0;
      wish_expert <= '0;
      wish_protect <= '0;
      for (int i = 0; i < MaxSlots; i++) begin
        slot_tag[i] <= '0;
        slot_stamp[i] <= '0;
      end
    end else begin
      if (cmd.settle && flight_valid) begin
        slot_busy[flight_slot] <= 1'b0;
        flight_valid <= 1'b0;
      end
      if (cmd.clr_wish) wish_valid <= 1'b0;
      if (cmd.set_wish) begin
        wish_valid <= 1'b1;
        wish_expert <= expert;
        wish_protect <= (prot_val) ? {1'b1, prot_id} : 9'd0;
      end
      if (cmd.load_victim) begin
        slot_tag[vic_slot] <= s_exp;
        slot_full[vic_slot] <= 1'b1;
        slot_busy[vic_slot] <= 1'b1;
        slot_spec[vic_slot] <= cmd.load_spec;
        flight_valid <= 1'b1;
        flight_slot <= vic_slot;
        use_clock <= use_clock + 32'd1;
        slot_stamp[vic_slot] <= use_clock + 32'd1;
      end
      if (cmd.touch_hit) begin
        use_clock <= use_clock + 32'd1;
        slot_stamp[found_slot] <= use_clock + 32'd1;
      end
      if (cmd.acquire_fix) slot_spec[found_slot] <= 1'b0;
    end
  end

  assign acq_out = slot_spec[found_slot] ? OUT_PHIT
                 : (slot_busy[found_slot] ? OUT_MISS : OUT_HIT);

  // answer contents
  always_comb begin
    ans_slot = '0;
    ans_ready = 1'b0;
    ans_out = OUT_NONE;
    case (op)
      OP_REQUEST: begin
        if (!stat.id_ok) ans_out = OUT_UNAV;
        else if (found) ans_slot = found_slot;
        else if (vic_ok) ans_slot = vic_slot;
        else ans_out = OUT_UNAV;
      end
      OP_ACQUIRE: begin
        if (!stat.id_ok) ans_out = OUT_UNAV;
        else if (found) begin
          ans_slot = found_slot; ans_ready = 1'b1; ans_out = acq_out;
        end else if (vic_ok) begin
          ans_slot = vic_slot; ans_ready = 1'b1; ans_out = OUT_MISS;
        end else ans_out = OUT_UNAV;
      end
      OP_PREFETCH: begin
        // a prefetch that loaded leaves its victim as the transfer in flight
        if (stat.id_ok && !stat.self_prot) begin
          if (found) ans_slot = found_slot;
          else if (vic_ok && flight_valid && flight_slot == vic_slot) ans_slot = vic_slot;
        end
      end
      OP_QUERY: begin
        if (found) begin
          ans_slot = found_slot; ans_ready = !slot_busy[found_slot];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_cmd || cmd.emit_ans) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_cmd) begin
      out_kind <= 1'b0;
      out_last <= 1'b0;
      out_data <= {3'd0, OUT_NONE, 1'b0, cmd.load_spec, acc[AddrW-1:0], flight_slot};
    end else if (cmd.emit_ans) begin
      out_kind <= 1'b1;
      out_last <= 1'b1;
      out_data <= {3'd0, ans_out, ans_ready, 1'b0, {AddrW{1'b0}}, ans_slot};
    end
  end

  assign stat.op = op;
  assign stat.id_ok = {1'b0, expert} < expert_count;
  assign stat.self_prot = prot_val && (expert == prot_id);
  assign stat.busy_in = busy;
  assign stat.flight_valid = flight_valid;
  assign stat.wish_valid = wish_valid;
  assign stat.wish_ok = {1'b0, wish_expert} < expert_count;
  assign stat.scan_done = (ptr >= used);
  assign stat.found = found;
  assign stat.found_busy = slot_busy[found_slot];
  assign stat.victim_ok = vic_ok;
  assign stat.mul_done = (mul_cnt == 4'd8);
  assign stat.out_full = out_valid && !out_ready;

  `LSC_ASSERT_IMP(a_flight_busy, flight_valid, slot_busy[flight_slot], "flight slot not busy")
  `LSC_ASSERT_IMP(a_busy_full, 1'b1, (slot_busy & ~slot_full) == '0, "busy slot not full")
  `LSC_ASSERT_IMP(a_emit_one, 1'b1, !(cmd.emit_cmd && cmd.emit_ans), "two emits at once")
  `LSC_ASSERT_ALWAYS(a_busy_one, $onehot0(slot_busy), "more than one busy slot")
endmodule

// ===== hw/rtl/lsc_ctrl.sv =====
`timescale 1ns / 1ps
`include "lru_slot_cache_with_prefetch_defines.svh"
module lsc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lsc_pkg::lsc_stat_t stat,
  output lsc_pkg::lsc_cmd_t  cmd
);
  import lsc_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CHECK  = 13'b0000000000010,
    S_WISH   = 13'b0000000000100,
    S_WSCAN  = 13'b0000000001000,
    S_WMUL   = 13'b0000000010000,
    S_WEMIT  = 13'b0000000100000,
    S_SCAN   = 13'b0000001000000,
    S_DECIDE = 13'b0000010000000,
    S_MUL    = 13'b0000100000000,
    S_EMIT   = 13'b0001000000000,
    S_ANS    = 13'b0010000000000,
    S_WAIT   = 13'b0100000000000,
    S_SEND   = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   spec, spec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      spec <= 1'b0;
    end else begin
      state <= state_next;
      spec <= spec_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    spec_next = spec;
    cmd = '0;
    cmd.load_spec = spec;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // ignored ids answer at once without polling
        if (stat.op != OP_QUERY && (!stat.id_ok ||
            (stat.op == OP_PREFETCH && stat.self_prot))) begin
          cmd.scan_start = 1'b1;
          state_next = S_ANS;
        end else if (stat.flight_valid && stat.busy_in) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end else begin
          cmd.settle = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = stat.wish_valid ? S_WISH : S_SCAN;
        end
      end
      S_WISH: begin
        cmd.clr_wish = 1'b1;
        cmd.scan_wish = 1'b1;
        state_next = stat.wish_ok ? S_WSCAN : S_SCAN;
      end
      S_WSCAN: begin
        cmd.scan_wish = 1'b1;
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          if (!stat.found && stat.victim_ok) begin
            cmd.load_victim = 1'b1;
            cmd.load_spec = 1'b1;
            cmd.mul_start = 1'b1;
            spec_next = 1'b1;
            state_next = S_WMUL;
          end else begin
            cmd.scan_start = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_WMUL: begin
        if (stat.mul_done && !stat.out_full) begin
          cmd.emit_cmd = 1'b1;
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = S_ANS;
        case (stat.op)
          OP_REQUEST: begin
            if (stat.found) cmd.touch_hit = 1'b1;
            else if (stat.victim_ok) state_next = S_MUL;
          end
          OP_ACQUIRE: begin
            if (stat.found) state_next = S_WAIT;
            else if (stat.victim_ok) state_next = S_MUL;
          end
          OP_PREFETCH: begin
            if (!stat.found) begin
              if (stat.flight_valid || !stat.victim_ok) cmd.set_wish = 1'b1;
              else state_next = S_MUL;
            end
          end
          default: ;
        endcase
        if (state_next == S_MUL) begin
          spec_next = (stat.op == OP_PREFETCH);
          cmd.load_spec = spec_next;
          cmd.mul_start = 1'b1;
          cmd.settle = 1'b1;
        end
      end
      S_MUL: begin
        if (stat.mul_done) begin
          cmd.load_victim = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_full) begin
          cmd.emit_cmd = 1'b1;
          cmd.settle = (stat.op == OP_ACQUIRE);
          state_next = S_ANS;
        end
      end
      S_WAIT: begin
        // answer is formed before spec clears; touch and settle after
        if (!stat.out_full) begin
          cmd.emit_ans = 1'b1;
          state_next = S_SEND;
        end
      end
      S_SEND: begin
        // only a hit on the slot still loading completes the transfer
        cmd.acquire_fix = 1'b1;
        cmd.touch_hit = 1'b1;
        cmd.settle = stat.found_busy;
        state_next = S_IDLE;
      end
      S_ANS: begin
        if (!stat.out_full) begin
          cmd.emit_ans = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `LSC_ASSERT_IMP(a_emit_ans_idle, cmd.emit_ans && state == S_ANS, state_next == S_IDLE,
                  "answer not last")
  `LSC_ASSERT_IMP(a_accept_idle, in_valid && in_ready, state == S_IDLE, "accept outside idle")
  `LSC_ASSERT_ALWAYS(a_onehot, $onehot(state), "state not one-hot")
endmodule

// ===== hw/rtl/lru_slot_cache_with_prefetch.sv =====
`timescale 1ns / 1ps
// Flow: an operation runs through slot scans (one slot a cycle, up to two scans) and
//   shift-add address waits before its answer is registered.
// Operations: one at a time; the next is taken only after the answer is registered.
//   A stalled result transfer holds the operation in place.
// Reset: synchronous, active high; all slots empty, no transfer, no pending prefetch,
//   registers back to base 0, length 8, one expert, one slot.
module lru_slot_cache_with_prefetch (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // operation, expert_id, protect_id, protect_valid, transfer_busy
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // slot_index, source_address, speculative, ready_res, outcome
  output logic        m_tuser,  // item_kind
  output logic        m_tlast
);
  import lsc_pkg::*;

  lsc_cmd_t  cmd;
  lsc_stat_t stat;

  lsc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  lsc_datapath u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_op(s_tdata[1:0]), .in_expert(s_tdata[9:2]), .in_protect(s_tdata[17:10]),
    .in_protect_valid(s_tdata[18]), .in_busy(s_tdata[19]),
    .cmd(cmd), .stat(stat),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata),
    .out_kind(m_tuser), .out_last(m_tlast)
  );
endmodule
